### hdl/mch_pkg.sv
package mch_pkg;

    localparam int MAX_CELLS  = 256;
    localparam int MAX_REFS   = 4;
    localparam int HASH_BYTES = 32;
    localparam int HASH_WORDS = HASH_BYTES / 8;
    localparam int CIDX_W     = $clog2(MAX_CELLS);
    localparam int HWORD_W    = $clog2(HASH_WORDS);
    localparam int QUEUE_DEPTH = 4;
    localparam logic [8:0] CELL_TOTAL_RST = 9'(MAX_CELLS);

    typedef struct packed {
        logic       first_byte;
        logic [7:0] cell_index;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] hash_word;
        logic [7:0]  cell_depth;
        logic [2:0]  error_code;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_HASHES,
        ERR_EXOTIC,
        ERR_REFS,
        ERR_BAD_REF
    } err_code_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_DATA,
        OP_FIN,
        OP_ERR
    } op_kind_t;

    typedef struct packed {
        op_kind_t        kind;
        logic [7:0]      data;
        logic            fin;
        logic [2:0]      nref;
        logic [3:0][7:0] child;
        logic [7:0]      idx;
        err_code_t       code;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DEP_ADDR,
        B_DEP_ZERO,
        B_DEP_VAL,
        B_HASH_ADDR,
        B_HASH_BYTE,
        B_PAD,
        B_ZERO,
        B_LEN,
        B_WAIT,
        B_EMIT,
        B_ERR_OUT
    } back_state_t;

    typedef enum logic {
        SHA_ABSORB,
        SHA_ROUND
    } sha_state_t;

    function automatic logic [31:0] sha_iv(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] r;
        case (i)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

### hdl/mch_front.sv
module mch_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mch_pkg::in_item_t s_data,
    input  logic              cfg_wr_en,
    input  logic [8:0]        cfg_wr_data,
    input  mch_pkg::q_stat_t  q_stat,
    output logic              push,
    output mch_pkg::op_t      op
);
    import mch_pkg::*;

    logic            busy_reg, busy_next;
    logic [7:0]      d1_reg, d1_next;
    logic [7:0]      d2_reg, d2_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic [7:0]      idx_reg, idx_next;
    logic [3:0][7:0] child_reg, child_next;
    logic [8:0]      total_reg;
    logic [7:0]      d2_eff, ndata, b, slot;
    logic [2:0]      nref;

    assign s_ready = !q_stat.full;
    assign b       = s_data.byte_value;
    assign nref    = d1_reg[2:0];
    assign d2_eff  = (cnt_reg == 8'd1) ? b : d2_reg;
    assign ndata   = {1'b0, d2_eff[7:1]} + {7'b0, d2_eff[0]};
    assign slot    = cnt_reg - 8'd2 - ndata;

    always_comb begin
        busy_next  = busy_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        child_next = child_reg;
        push       = 1'b0;
        op         = '0;
        op.kind    = OP_DATA;
        op.code    = ERR_NONE;
        op.data    = b;
        if (s_valid && s_ready) begin
            if (s_data.first_byte) begin
                idx_next = s_data.cell_index;
                d1_next  = b;
                d2_next  = 8'd0;
                cnt_next = 8'd1;
                busy_next = 1'b0;
                push     = 1'b1;
                if (b[4]) begin
                    op.kind = OP_ERR;
                    op.code = ERR_HASHES;
                end else if (b[3]) begin
                    op.kind = OP_ERR;
                    op.code = ERR_EXOTIC;
                end else if (b[2:0] > 3'(MAX_REFS)) begin
                    op.kind = OP_ERR;
                    op.code = ERR_REFS;
                end else begin
                    op.kind   = OP_START;
                    busy_next = 1'b1;
                end
            end else if (busy_reg) begin
                if (cnt_reg == 8'd1) begin
                    d2_next = b;
                    push    = 1'b1;
                end else if (cnt_reg < 8'd2 + ndata) begin
                    push = 1'b1;
                end else if (b <= idx_reg || {1'b0, b} >= total_reg
                             || {1'b0, b} >= 9'(MAX_CELLS)) begin
                    push      = 1'b1;
                    op.kind   = OP_ERR;
                    op.code   = ERR_BAD_REF;
                    busy_next = 1'b0;
                end else begin
                    child_next[slot[1:0]] = b;
                end
                if (busy_next) begin
                    cnt_next = cnt_reg + 8'd1;
                    if (cnt_next == 8'd2 + ndata + {5'b0, nref}) begin
                        busy_next = 1'b0;
                        if (push) begin
                            op.fin = 1'b1;
                        end else begin
                            push    = 1'b1;
                            op.kind = OP_FIN;
                        end
                    end
                end
            end
        end
        op.nref  = d1_next[2:0];
        op.child = child_next;
        op.idx   = idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            d1_reg    <= 8'd0;
            d2_reg    <= 8'd0;
            cnt_reg   <= 8'd0;
            idx_reg   <= 8'd0;
            total_reg <= CELL_TOTAL_RST;
        end else begin
            busy_reg <= busy_next;
            d1_reg   <= d1_next;
            d2_reg   <= d2_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            if (cfg_wr_en) begin
                total_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        child_reg <= child_next;
    end

endmodule

### hdl/mch_queue.sv
module mch_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mch_pkg::op_t      push_op,
    input  logic              pop,
    output mch_pkg::op_t      head_op,
    output mch_pkg::q_stat_t  q_stat
);
    import mch_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    op_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [PTR_W:0]   cnt_reg;

    assign head_op      = mem_reg[rp_reg];
    assign q_stat.full  = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

endmodule

### hdl/mch_sha.sv
module mch_sha (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic         put_valid,
    input  logic [7:0]   put_byte,
    output logic         put_ready,
    output logic         busy,
    output logic [5:0]   fill,
    output logic [255:0] digest
);
    import mch_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    sha_state_t  st_reg, st_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [23:0] acc_reg;
    logic [5:0]  fill_reg, fill_eff;
    logic [6:0]  rnd_reg;
    logic        put_acc;
    logic [31:0] t1, t2, w_new, s0e, s1e, ch, maj;

    assign put_acc  = put_valid && put_ready;
    assign fill_eff = start ? 6'd0 : fill_reg;
    assign fill     = fill_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            SHA_ABSORB: if (put_acc && fill_eff == 6'd63) st_next = SHA_ROUND;
            SHA_ROUND:  if (rnd_reg == 7'd64) st_next = SHA_ABSORB;
            default:    st_next = SHA_ABSORB;
        endcase
    end

    always_comb begin
        put_ready = 1'b0;
        busy      = 1'b0;
        unique case (st_reg)
            SHA_ABSORB: put_ready = 1'b1;
            SHA_ROUND:  busy = 1'b1;
            default:    busy = 1'b0;
        endcase
    end

    always_comb begin
        s1e = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + s1e + ch + round_k(rnd_reg[5:0]) + w_reg[0];
        s0e = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = s0e + maj;
        w_new = (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10))
              + w_reg[9]
              + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
              + w_reg[0];
    end

    for (genvar i = 0; i < 8; i++) begin : g_dig
        assign digest[255 - 32*i -: 32] = h_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= SHA_ABSORB;
            fill_reg <= 6'd0;
            rnd_reg  <= 7'd0;
        end else begin
            st_reg <= st_next;
            if (start) begin
                fill_reg <= 6'd0;
            end
            if (put_acc) begin
                fill_reg <= fill_eff + 6'd1;
            end
            if (st_reg == SHA_ROUND) begin
                rnd_reg <= (rnd_reg == 7'd64) ? 7'd0 : rnd_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha_iv(3'(i));
            end
        end else if (start) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha_iv(3'(i));
            end
        end else if (st_reg == SHA_ROUND && rnd_reg == 7'd64) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (put_acc) begin
            acc_reg <= {acc_reg[15:0], put_byte};
            if (fill_eff[1:0] == 2'd3) begin
                for (int i = 0; i < 15; i++) begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= {acc_reg, put_byte};
            end
        end else if (st_reg == SHA_ROUND && rnd_reg != 7'd64) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
        if (st_reg == SHA_ABSORB) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
            if (put_acc && fill_eff == 6'd63 && start) begin
                for (int i = 0; i < 8; i++) begin
                    v_reg[i] <= sha_iv(3'(i));
                end
            end
        end else if (rnd_reg != 7'd64) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

### hdl/mch_back.sv
module mch_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  mch_pkg::op_t       head_op,
    input  mch_pkg::q_stat_t   q_stat,
    output logic               pop,
    output logic               sha_start,
    output logic               put_valid,
    output logic [7:0]         put_byte,
    input  logic               put_ready,
    input  logic               sha_busy,
    input  logic [5:0]         sha_fill,
    input  logic [255:0]       digest,
    output logic               m_valid,
    input  logic               m_ready,
    output mch_pkg::out_item_t m_data
);
    import mch_pkg::*;

    back_state_t     st_reg, st_next;
    logic [2:0]      nref_reg;
    logic [3:0][7:0] child_reg;
    logic [7:0]      idx_reg;
    logic [2:0]      ci_reg;
    logic [HWORD_W-1:0] k_reg;
    logic [2:0]      bsel_reg;
    logic [7:0]      top_reg;
    logic [8:0]      len_reg;
    err_code_t       code_reg;
    out_item_t       out_reg, out_next;
    logic            out_valid_reg, out_load, out_free;

    logic [63:0]     hash_mem [MAX_CELLS*HASH_WORDS];
    logic [7:0]      dep_mem [MAX_CELLS];
    logic [MAX_CELLS-1:0] valid_reg;
    logic [63:0]     hash_rd_reg;
    logic [7:0]      dep_rd_reg;
    logic            vld_rd_reg;

    logic [7:0]      child, dep_val, dep_out;
    logic [63:0]     hash_val, hash_sh, len_sh;
    logic [255:0]    dig_sh;
    logic            put_acc, last_child, fin_op;

    assign child      = child_reg[ci_reg[1:0]];
    assign put_acc    = put_valid && put_ready;
    assign last_child = (ci_reg + 3'd1 == nref_reg);
    assign dep_val    = vld_rd_reg ? dep_rd_reg : 8'd0;
    assign hash_val   = vld_rd_reg ? hash_rd_reg : 64'd0;
    assign hash_sh    = hash_val >> {~bsel_reg, 3'b000};
    assign len_sh     = {52'd0, len_reg, 3'b000} >> {~bsel_reg, 3'b000};
    assign dig_sh     = digest << {k_reg, 6'd0};
    assign dep_out    = (nref_reg != 3'd0) ? top_reg + 8'd1 : 8'd0;
    assign out_free   = !out_valid_reg || m_ready;
    assign fin_op     = (head_op.kind == OP_FIN) || (head_op.kind == OP_DATA && head_op.fin);
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            B_IDLE: begin
                if (pop) begin
                    if (head_op.kind == OP_ERR) begin
                        st_next = B_ERR_OUT;
                    end else if (fin_op) begin
                        st_next = (head_op.nref != 3'd0) ? B_DEP_ADDR : B_PAD;
                    end
                end
            end
            B_DEP_ADDR:  st_next = B_DEP_ZERO;
            B_DEP_ZERO:  if (put_acc) st_next = B_DEP_VAL;
            B_DEP_VAL:   if (put_acc) st_next = last_child ? B_HASH_ADDR : B_DEP_ADDR;
            B_HASH_ADDR: st_next = B_HASH_BYTE;
            B_HASH_BYTE: begin
                if (put_acc && bsel_reg == 3'd7) begin
                    if (k_reg == HWORD_W'(HASH_WORDS - 1) && last_child) begin
                        st_next = B_PAD;
                    end else begin
                        st_next = B_HASH_ADDR;
                    end
                end
            end
            B_PAD:     if (put_acc) st_next = B_ZERO;
            B_ZERO:    if (put_ready && sha_fill == 6'd56) st_next = B_LEN;
            B_LEN:     if (put_acc && bsel_reg == 3'd7) st_next = B_WAIT;
            B_WAIT:    if (!sha_busy) st_next = B_EMIT;
            B_EMIT: begin
                if (out_free && k_reg == HWORD_W'(HASH_WORDS - 1)) st_next = B_IDLE;
            end
            B_ERR_OUT: if (out_free) st_next = B_IDLE;
            default:   st_next = B_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        sha_start = 1'b0;
        put_valid = 1'b0;
        put_byte  = 8'd0;
        out_load  = 1'b0;
        out_next  = '0;
        unique case (st_reg)
            B_IDLE: begin
                if (!q_stat.empty && !sha_busy) begin
                    pop = 1'b1;
                    if (head_op.kind == OP_START) begin
                        sha_start = 1'b1;
                        put_valid = 1'b1;
                        put_byte  = head_op.data;
                    end else if (head_op.kind == OP_DATA) begin
                        put_valid = 1'b1;
                        put_byte  = head_op.data;
                    end
                end
            end
            B_DEP_ZERO: put_valid = 1'b1;
            B_DEP_VAL: begin
                put_valid = 1'b1;
                put_byte  = dep_val;
            end
            B_HASH_BYTE: begin
                put_valid = 1'b1;
                put_byte  = hash_sh[7:0];
            end
            B_PAD: begin
                put_valid = 1'b1;
                put_byte  = 8'h80;
            end
            B_ZERO: put_valid = (sha_fill != 6'd56);
            B_LEN: begin
                put_valid = 1'b1;
                put_byte  = len_sh[7:0];
            end
            B_EMIT: begin
                out_load            = out_free;
                out_next.hash_word  = dig_sh[255:192];
                out_next.cell_depth = dep_out;
                out_next.error_code = ERR_NONE;
                out_next.last       = (k_reg == HWORD_W'(HASH_WORDS - 1));
            end
            B_ERR_OUT: begin
                out_load            = out_free;
                out_next.error_code = code_reg;
                out_next.last       = 1'b1;
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= B_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end else begin
            st_reg <= st_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (st_reg == B_EMIT && out_load && k_reg == HWORD_W'(HASH_WORDS - 1)
                && {1'b0, idx_reg} < 9'(MAX_CELLS)) begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_next;
        end
        if (pop) begin
            if (head_op.kind == OP_START) begin
                len_reg <= 9'd1;
            end else if (head_op.kind == OP_DATA) begin
                len_reg <= len_reg + 9'd1;
            end
            if (head_op.kind == OP_ERR) begin
                code_reg <= head_op.code;
            end
            if (fin_op) begin
                nref_reg  <= head_op.nref;
                child_reg <= head_op.child;
                idx_reg   <= head_op.idx;
                ci_reg    <= 3'd0;
                k_reg     <= '0;
                top_reg   <= 8'd0;
            end
        end
        case (st_reg)
            B_DEP_ZERO: if (put_acc) len_reg <= len_reg + 9'd1;
            B_DEP_VAL: begin
                if (put_acc) begin
                    len_reg <= len_reg + 9'd1;
                    if (dep_val > top_reg) top_reg <= dep_val;
                    ci_reg <= last_child ? 3'd0 : ci_reg + 3'd1;
                end
            end
            B_HASH_ADDR: bsel_reg <= 3'd0;
            B_HASH_BYTE: begin
                if (put_acc) begin
                    len_reg  <= len_reg + 9'd1;
                    bsel_reg <= bsel_reg + 3'd1;
                    if (bsel_reg == 3'd7) begin
                        k_reg <= k_reg + 1'b1;
                        if (k_reg == HWORD_W'(HASH_WORDS - 1)) ci_reg <= ci_reg + 3'd1;
                    end
                end
            end
            B_PAD:  bsel_reg <= 3'd0;
            B_LEN:  if (put_acc) bsel_reg <= bsel_reg + 3'd1;
            B_WAIT: k_reg <= '0;
            B_EMIT: if (out_load) k_reg <= k_reg + 1'b1;
            default: bsel_reg <= bsel_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_reg == B_EMIT && out_load && {1'b0, idx_reg} < 9'(MAX_CELLS)) begin
            hash_mem[{idx_reg, k_reg}] <= dig_sh[255:192];
        end
        hash_rd_reg <= hash_mem[{child, k_reg}];
    end

    always_ff @(posedge aclk) begin
        if (st_reg == B_EMIT && out_load && k_reg == HWORD_W'(HASH_WORDS - 1)
            && {1'b0, idx_reg} < 9'(MAX_CELLS)) begin
            dep_mem[idx_reg] <= dep_out;
        end
        dep_rd_reg <= dep_mem[child];
        vld_rd_reg <= valid_reg[child];
    end

endmodule

### hdl/merkle_cell_hasher_top.sv
// results: a cell's results start after its last item once each of its 64-byte sha-256 blocks is hashed,
// plus the trailer walk over the depth of each reference and each child hash word
// throughput: one item per cycle into a 4-deep queue while it is not full; the back end absorbs
// at most one byte a cycle and stalls while the one-round-per-cycle sha-256 core is busy
// reset: synchronous, active low; depth and hash tables read as zero via per-cell valid flags
module merkle_cell_hasher_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mch_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mch_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [8:0]         cfg_wr_data
);
    import mch_pkg::*;

    q_stat_t      q_stat;
    op_t          push_op, head_op;
    logic         push, pop;
    logic         sha_start, put_valid, put_ready, sha_busy;
    logic [7:0]   put_byte;
    logic [5:0]   sha_fill;
    logic [255:0] digest;

    mch_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .push        (push),
        .op          (push_op)
    );

    mch_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .q_stat  (q_stat)
    );

    mch_sha u_sha (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (sha_start),
        .put_valid (put_valid),
        .put_byte  (put_byte),
        .put_ready (put_ready),
        .busy      (sha_busy),
        .fill      (sha_fill),
        .digest    (digest)
    );

    mch_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_op   (head_op),
        .q_stat    (q_stat),
        .pop       (pop),
        .sha_start (sha_start),
        .put_valid (put_valid),
        .put_byte  (put_byte),
        .put_ready (put_ready),
        .sha_busy  (sha_busy),
        .sha_fill  (sha_fill),
        .digest    (digest),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_stat.full))
        else $error("queue overflow");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_stat.empty))
        else $error("queue underflow");

    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != 3'(ERR_NONE) |-> m_data.last && m_data.hash_word == '0)
        else $error("error item malformed");

    a_mid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.error_code == 3'(ERR_NONE))
        else $error("error on non-final item");
`endif

endmodule
